>>> src/color_keyed_percent_blend_top_defines.svh
// Assertion macros shared by the checker of the compositor.
`ifndef COLOR_KEYED_PERCENT_BLEND_TOP_DEFINES_SVH
`define COLOR_KEYED_PERCENT_BLEND_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define CKPB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define CKPB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/ckpb_pkg.sv
// Shared types, constants and register codes of the color-keyed blender.
`default_nettype none
package ckpb_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned RgbW    = 24;
  localparam int unsigned RawW    = 32;
  localparam int unsigned PctW    = 7;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NumChan = 3;

  // Products and sums of one channel stay at or below 255 * 100 = 25500.
  localparam int unsigned ProdW = 15;

  // Division by 100 as a multiply by 5243 and a right shift by 19.
  localparam int unsigned RecipW = 13;
  localparam int unsigned RecipShift = 19;
  localparam logic [RecipW-1:0] Recip100 = 13'd5243;
  localparam int unsigned QuotFullW = ProdW + RecipW;

  localparam logic [PctW-1:0] FullPct = 7'd100;

  typedef enum logic [ModeW-1:0] {
    MODE_BLEND_SRC  = 2'd0,
    MODE_REPLACE    = 2'd1,
    MODE_BLEND_REPL = 2'd2
  } blend_mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_COLOUR     = 3'd0,
    REG_REPLACE_COLOUR = 3'd1,
    REG_OPACITY        = 3'd2,
    REG_BLEND_MODE     = 3'd3
  } cfg_reg_t;

  // Current register contents.
  typedef struct packed {
    logic [RawW-1:0]  key_colour;
    logic [RgbW-1:0]  replace_colour;
    logic [PctW-1:0]  opacity;
    logic [ModeW-1:0] mode;
  } ckpb_cfg_t;

  // Load enables of the back stages of the datapath.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } ckpb_adv_t;

endpackage
`default_nettype wire

>>> src/ckpb_cfg.sv
// Configuration register file with opacity saturation.
`default_nettype none
module ckpb_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ckpb_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ckpb_pkg::CfgDataW-1:0] cfg_data,
  output ckpb_pkg::ckpb_cfg_t           cfg
);
  import ckpb_pkg::*;

  logic [PctW-1:0] opacity_next;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  // Values above one hundred percent saturate.
  always_comb begin
    if (cfg_data[PctW-1:0] > FullPct) begin
      opacity_next = FullPct;
    end else begin
      opacity_next = cfg_data[PctW-1:0];
    end
  end

  // Register file; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_colour     <= '0;
      cfg.replace_colour <= '0;
      cfg.opacity        <= FullPct;
      cfg.mode           <= MODE_BLEND_SRC;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_COLOUR:     cfg.key_colour     <= cfg_data[RawW-1:0];
        REG_REPLACE_COLOUR: cfg.replace_colour <= cfg_data[RgbW-1:0];
        REG_OPACITY:        cfg.opacity        <= opacity_next;
        REG_BLEND_MODE:     cfg.mode           <= cfg_data[ModeW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/ckpb_front.sv
// First stage: key compare and choice of foreground color and weight.
`default_nettype none
module ckpb_front (
  input  logic                       clk,
  input  logic                       en,
  input  ckpb_pkg::ckpb_cfg_t        cfg,
  input  logic [ckpb_pkg::RawW-1:0]  source_pixel,
  input  logic [ckpb_pkg::RgbW-1:0]  background_pixel,
  output logic                       s1_we,
  output logic [ckpb_pkg::RgbW-1:0]  s1_fg,
  output logic [ckpb_pkg::RgbW-1:0]  s1_bg,
  output logic [ckpb_pkg::PctW-1:0]  s1_op
);
  import ckpb_pkg::*;

  logic [RgbW-1:0] fg_next;
  logic [PctW-1:0] op_next;

  // Plain replace is a blend of the replace color at full weight.
  always_comb begin
    unique case (cfg.mode)
      MODE_REPLACE: begin
        fg_next = cfg.replace_colour;
        op_next = FullPct;
      end
      MODE_BLEND_REPL: begin
        fg_next = cfg.replace_colour;
        op_next = cfg.opacity;
      end
      default: begin
        fg_next = source_pixel[RgbW-1:0];
        op_next = cfg.opacity;
      end
    endcase
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_we <= (source_pixel != cfg.key_colour);
      s1_fg <= fg_next;
      s1_bg <= background_pixel;
      s1_op <= op_next;
    end
  end

endmodule
`default_nettype wire

>>> src/ckpb_mix.sv
// Back stages: weighted products, channel sums and division by one hundred.
`default_nettype none
module ckpb_mix (
  input  logic                       clk,
  input  ckpb_pkg::ckpb_adv_t        adv,
  input  logic                       s1_we,
  input  logic [ckpb_pkg::RgbW-1:0]  s1_fg,
  input  logic [ckpb_pkg::RgbW-1:0]  s1_bg,
  input  logic [ckpb_pkg::PctW-1:0]  s1_op,
  output logic                       write_enable,
  output logic [ckpb_pkg::RgbW-1:0]  pixel_out
);
  import ckpb_pkg::*;

  logic [ProdW-1:0]     prod_fg [NumChan];
  logic [ProdW-1:0]     prod_bg [NumChan];
  logic [ProdW-1:0]     sum     [NumChan];
  logic [QuotFullW-1:0] quot_full [NumChan];
  logic [PctW-1:0]      op_inv;
  logic                 s2_we;
  logic                 s3_we;

  assign op_inv = FullPct - s1_op;

  // Stage two: per-channel products of foreground and background.
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      s2_we <= s1_we;
      for (int c = 0; c < NumChan; c++) begin
        prod_fg[c] <= ProdW'(s1_fg[c*ChanW +: ChanW] * s1_op);
        prod_bg[c] <= ProdW'(s1_bg[c*ChanW +: ChanW] * op_inv);
      end
    end
  end

  // Stage three: weighted sum of each channel.
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      s3_we <= s2_we;
      for (int c = 0; c < NumChan; c++) begin
        sum[c] <= prod_fg[c] + prod_bg[c];
      end
    end
  end

  // Reciprocal multiply; exact floor for sums up to 25500.
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      quot_full[c] = QuotFullW'(sum[c]) * QuotFullW'(Recip100);
    end
  end

  // Stage four: quotient, forced to zero for a keyed pixel.
  always_ff @(posedge clk) begin
    if (adv.s4) begin
      write_enable <= s3_we;
      for (int c = 0; c < NumChan; c++) begin
        if (s3_we) begin
          pixel_out[c*ChanW +: ChanW] <= quot_full[c][RecipShift +: ChanW];
        end else begin
          pixel_out[c*ChanW +: ChanW] <= '0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/color_keyed_percent_blend_top.sv
// Throughput: one pixel per clock unless the output stalls; the four stage
// registers (front stage, stages two to four) each hold one pixel. A stalled
// output holds its result and the stages behind it fill before the input
// stalls. Reset (rst, synchronous) empties every stage and sets key and
// replace color to zero, opacity to 100 percent and the mode to source blend.
`default_nettype none
module color_keyed_percent_blend_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ckpb_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ckpb_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  logic [ckpb_pkg::RawW-1:0]     source_pixel,
  input  logic [ckpb_pkg::RgbW-1:0]     background_pixel,
  output logic                          wr_valid,
  input  logic                          wr_stall,
  output logic                          write_enable,
  output logic [ckpb_pkg::RgbW-1:0]     pixel_out
);
  import ckpb_pkg::*;

  localparam int unsigned NumStages = 4;

  ckpb_cfg_t              cfg;
  ckpb_adv_t              adv;
  logic [NumStages-1:0]   vld;
  logic [NumStages-1:0]   rdy;
  logic                   s1_we;
  logic [RgbW-1:0]        s1_fg;
  logic [RgbW-1:0]        s1_bg;
  logic [PctW-1:0]        s1_op;

  ckpb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    rdy[NumStages-1] = !vld[NumStages-1] || !wr_stall;
    for (int i = NumStages - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign adv.s2    = rdy[1];
  assign adv.s3    = rdy[2];
  assign adv.s4    = rdy[3];
  assign pix_stall = !rdy[0];
  assign wr_valid  = vld[NumStages-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= pix_valid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  ckpb_front u_front (
    .clk              (clk),
    .en               (rdy[0]),
    .cfg              (cfg),
    .source_pixel     (source_pixel),
    .background_pixel (background_pixel),
    .s1_we            (s1_we),
    .s1_fg            (s1_fg),
    .s1_bg            (s1_bg),
    .s1_op            (s1_op)
  );

  ckpb_mix u_mix (
    .clk          (clk),
    .adv          (adv),
    .s1_we        (s1_we),
    .s1_fg        (s1_fg),
    .s1_bg        (s1_bg),
    .s1_op        (s1_op),
    .write_enable (write_enable),
    .pixel_out    (pixel_out)
  );

endmodule
`default_nettype wire

>>> src/ckpb_checker.sv
// Port-level checker of the compositor and its bind to the top level.
`default_nettype none
`include "color_keyed_percent_blend_top_defines.svh"
module ckpb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic                      pix_stall,
  input logic                      wr_valid,
  input logic                      wr_stall,
  input logic                      write_enable,
  input logic [ckpb_pkg::RgbW-1:0] pixel_out
);

  // Reset leaves the pipeline empty.
  `CKPB_ASSERT_ALWAYS(a_empty_after_rst, clk, rst |=> !wr_valid, "result after reset")

  // With the output empty every stage can move, so the input never stalls.
  `CKPB_ASSERT(a_no_stall_when_empty, clk, rst, !wr_valid |-> !pix_stall, "input stalled while empty")

  // Register writes are never held off.
  `CKPB_ASSERT(a_cfg_always_ready, clk, rst, cfg_valid |-> cfg_ready, "config write refused")

  // A stalled result transaction stays and holds its payload.
  `CKPB_ASSERT(a_result_holds, clk, rst, wr_valid && wr_stall |=> wr_valid && $stable(write_enable) && $stable(pixel_out), "stalled result changed")

endmodule

bind color_keyed_percent_blend_top ckpb_checker u_ckpb_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready),
  .pix_stall    (pix_stall),
  .wr_valid     (wr_valid),
  .wr_stall     (wr_stall),
  .write_enable (write_enable),
  .pixel_out    (pixel_out)
);
`default_nettype wire
